// ----- hw/rtl/psld_pkg.sv -----
// ----------------------------------------------------------------------------
// psld_pkg
// shared types and codes for the pushbutton short/long press debouncer
// ----------------------------------------------------------------------------
package psld_pkg;

	// debounce machine states
	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_DOWN     = 3'd1,
		ST_PRESSED  = 3'd2,
		ST_RELEASED = 3'd3,
		ST_LONG     = 3'd4
	} state_t;

	// configuration register indexes
	localparam logic CFG_DEBOUNCE   = 1'b0;
	localparam logic CFG_LONG_PRESS = 1'b1;

	localparam int unsigned CFG_BITS  = 16;
	localparam int unsigned NOW_BITS  = 32;
	localparam int unsigned IN_BYTES  = 5;
	localparam int unsigned OUT_BYTES = 1;

	localparam logic [CFG_BITS-1:0] DEBOUNCE_RST   = 16'd20;
	localparam logic [CFG_BITS-1:0] LONG_PRESS_RST = 16'd1000;

	// per-item press flags
	typedef struct packed {
		logic long_press;
		logic short_press;
	} flags_t;

endpackage

// ----- hw/rtl/psld_fsm.sv -----
// ----------------------------------------------------------------------------
// psld_fsm
// debounce state machine with debounce and long press deadlines
// ----------------------------------------------------------------------------
module psld_fsm #(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  logic                              button_down,
	input  logic [TIME_BITS-1:0]              now,
	input  logic [psld_pkg::CFG_BITS-1:0]     debounce_ms,
	input  logic [psld_pkg::CFG_BITS-1:0]     long_press_ms,
	output psld_pkg::flags_t                  flags
);

	psld_pkg::state_t state_q, state_d;
	logic [TIME_BITS-1:0] deb_dl_q, deb_dl_d;
	logic [TIME_BITS-1:0] long_dl_q, long_dl_d;
	logic [TIME_BITS-1:0] deb_sum, long_sum;
	logic                 deb_hit, long_hit, long_en;

	// deadlines wrap at the time width
	assign deb_sum  = now + TIME_BITS'(debounce_ms);
	assign long_sum = now + TIME_BITS'(long_press_ms);
	assign deb_hit  = now > deb_dl_q;
	assign long_hit = now > long_dl_q;
	assign long_en  = long_press_ms != '0;

	// next state and deadlines
	always_comb begin
		state_d   = state_q;
		deb_dl_d  = deb_dl_q;
		long_dl_d = long_dl_q;
		unique case (state_q)
			psld_pkg::ST_IDLE: begin
				if (button_down) begin
					deb_dl_d = deb_sum;
					state_d  = psld_pkg::ST_DOWN;
				end
			end
			psld_pkg::ST_DOWN: begin
				if (!button_down) begin
					state_d = psld_pkg::ST_IDLE;
				end else if (deb_hit) begin
					if (long_en) long_dl_d = long_sum;
					state_d = psld_pkg::ST_PRESSED;
				end
			end
			psld_pkg::ST_PRESSED: begin
				if (!button_down) begin
					deb_dl_d  = deb_sum;
					long_dl_d = long_sum;
					state_d   = psld_pkg::ST_RELEASED;
				end else if (long_en && long_hit) begin
					state_d = psld_pkg::ST_LONG;
				end
			end
			psld_pkg::ST_RELEASED: begin
				if (button_down) begin
					state_d = psld_pkg::ST_PRESSED;
				end else if (deb_hit) begin
					state_d = psld_pkg::ST_IDLE;
				end
			end
			psld_pkg::ST_LONG: begin
				if (!button_down) state_d = psld_pkg::ST_IDLE;
			end
			default: begin
				state_d = psld_pkg::ST_IDLE;
			end
		endcase
	end

	// flags for the current item
	always_comb begin
		flags = '0;
		unique case (state_q)
			psld_pkg::ST_DOWN: begin
				flags.short_press = button_down && deb_hit && !long_en;
			end
			psld_pkg::ST_PRESSED: begin
				if (button_down) begin
					flags.long_press  = long_en && long_hit;
					flags.short_press = !long_en;
				end
			end
			psld_pkg::ST_RELEASED: begin
				flags.short_press = !button_down && deb_hit && long_en;
			end
			default: begin
				flags = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= psld_pkg::ST_IDLE;
			deb_dl_q  <= '0;
			long_dl_q <= '0;
		end else if (step) begin
			state_q   <= state_d;
			deb_dl_q  <= deb_dl_d;
			long_dl_q <= long_dl_d;
		end
	end

endmodule

// ----- hw/rtl/pushbutton_short_long_debounce_unit.sv -----
// ----------------------------------------------------------------------------
// pushbutton_short_long_debounce_unit
// pushbutton debouncer reporting short and long presses per time sample
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_axis    in         button level and millisecond time, one sample per item
//  m_axis    out        short and long press flags, one item per sample
//  cfg       in         debounce and long press hold times in ms
//
//  two stages: an input register, then the state machine feeding the
//  result register; one item per cycle while the output is not stalled
//  the state machine steps only when the input register moves into the
//  result register, so a stalled output holds state and deadlines
//  s_tready stays high while the result register is free or being taken
//  reset clears the machine to idle, deadlines to zero and the hold
//  times to 20 ms and 1000 ms
// ----------------------------------------------------------------------------
module pushbutton_short_long_debounce_unit #(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// input items
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	input  logic [psld_pkg::IN_BYTES*8-1:0]         s_tdata,  // button_down, now_ms[31:0], zeros
	// result items
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	output logic [psld_pkg::OUT_BYTES*8-1:0]        m_tdata,  // short_press, long_press, zeros
	// configuration writes
	input  logic                                    cfg_we,
	input  logic                                    cfg_index,
	input  logic [psld_pkg::CFG_BITS-1:0]           cfg_data
);

	// configuration registers
	logic [psld_pkg::CFG_BITS-1:0] debounce_ms_q;
	logic [psld_pkg::CFG_BITS-1:0] long_press_ms_q;

	// input stage
	logic                          valid_s1;
	logic                          button_down_s1;
	logic [psld_pkg::NOW_BITS-1:0] now_ms_s1;

	// result stage
	logic                          valid_s2;
	psld_pkg::flags_t              flags_s2;

	logic                          advance;
	logic [TIME_BITS-1:0]          now_t;
	psld_pkg::flags_t              flags;

	// the stage moves when the result register is free or emptying
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// time sample fitted to the time width: truncated or zero-extended
	generate
		for (genvar i = 0; i < TIME_BITS; i++) begin : g_now
			if (i < psld_pkg::NOW_BITS) begin : g_bit
				assign now_t[i] = now_ms_s1[i];
			end else begin : g_zero
				assign now_t[i] = 1'b0;
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ms_q   <= psld_pkg::DEBOUNCE_RST;
			long_press_ms_q <= psld_pkg::LONG_PRESS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				psld_pkg::CFG_DEBOUNCE:   debounce_ms_q   <= cfg_data;
				psld_pkg::CFG_LONG_PRESS: long_press_ms_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			button_down_s1 <= s_tdata[0];
			now_ms_s1      <= s_tdata[psld_pkg::NOW_BITS:1];
		end
	end

	psld_fsm #(
		.TIME_BITS (TIME_BITS)
	) u_fsm (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.button_down   (button_down_s1),
		.now           (now_t),
		.debounce_ms   (debounce_ms_q),
		.long_press_ms (long_press_ms_q),
		.flags         (flags)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			flags_s2 <= flags;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(psld_pkg::OUT_BYTES*8-2){1'b0}},
	                   flags_s2.long_press, flags_s2.short_press};

endmodule

// ----- tb/tb_pushbutton_short_long_debounce_unit.sv -----
// ----------------------------------------------------------------------------
// tb_pushbutton_short_long_debounce_unit
// self-checking bench for the short/long press debouncer
// ----------------------------------------------------------------------------
//  button samples go in on s_axis; a local model of the press machine predicts
//  the flags of each sample at the moment the sample is taken. Each result
//  item is compared with the oldest prediction
//  a few directed sequences come first: reset hold times, bounce, re-press,
//  short and long press, time wrap. A first random batch and a long press
//  disabled sequence follow; then random press gestures with bounce and noise
//  run under several hold time settings, the extremes among them
//  both sides idle in random bursts, except in the last phase
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_pushbutton_short_long_debounce_unit;

	// quiet cycles before the run is declared hung
	localparam int unsigned HANG_LIMIT = 1000;
	// cycles to let the two pipeline stages empty out
	localparam int unsigned SETTLE_CYCLES = 6;

	logic                                clk;
	logic                                arst_n;
	logic                                s_tvalid;
	logic                                s_tready;
	logic [psld_pkg::IN_BYTES*8-1:0]     s_tdata;   // button_down, now_ms[31:0], zeros
	logic                                m_tvalid;
	logic                                m_tready;
	logic [psld_pkg::OUT_BYTES*8-1:0]    m_tdata;   // short_press, long_press, zeros
	logic                                cfg_we;
	logic                                cfg_index;
	logic [psld_pkg::CFG_BITS-1:0]       cfg_data;

	pushbutton_short_long_debounce_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// local copy of the press machine
	psld_pkg::state_t              press_st;
	logic [psld_pkg::NOW_BITS-1:0] db_deadline;
	logic [psld_pkg::NOW_BITS-1:0] lp_deadline;
	logic [psld_pkg::CFG_BITS-1:0] hold_db;
	logic [psld_pkg::CFG_BITS-1:0] hold_lp;

	psld_pkg::flags_t              press_flags_q[$];

	int unsigned                   mismatches;
	int unsigned                   results_seen;
	int unsigned                   sent_count;
	int unsigned                   quiet_cycles;
	int unsigned                   stall_left;
	bit                            idle_on;

	// time base of the generated samples and the largest step between them
	logic [psld_pkg::NOW_BITS-1:0] cur_ms;
	int unsigned                   tick_max;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hold time zero-extended to the time width
	function automatic logic [psld_pkg::NOW_BITS-1:0] hold_span(
		logic [psld_pkg::CFG_BITS-1:0] h);
		return {{(psld_pkg::NOW_BITS-psld_pkg::CFG_BITS){1'b0}}, h};
	endfunction

	// flags of one sample; advances the local machine
	function automatic psld_pkg::flags_t next_press_flags(bit down,
		logic [psld_pkg::NOW_BITS-1:0] now);
		psld_pkg::flags_t f;
		f = '0;
		case (press_st)
			psld_pkg::ST_IDLE: begin
				if (down) begin
					db_deadline = now + hold_span(hold_db);
					press_st = psld_pkg::ST_DOWN;
				end
			end
			psld_pkg::ST_DOWN: begin
				if (!down) begin
					press_st = psld_pkg::ST_IDLE;
				end else if (now > db_deadline) begin
					if (hold_lp != '0)
						lp_deadline = now + hold_span(hold_lp);
					else
						f.short_press = 1'b1;
					press_st = psld_pkg::ST_PRESSED;
				end
			end
			psld_pkg::ST_PRESSED: begin
				if (!down) begin
					// release debounce; long deadline restarts from here
					db_deadline = now + hold_span(hold_db);
					lp_deadline = now + hold_span(hold_lp);
					press_st = psld_pkg::ST_RELEASED;
				end else if (hold_lp != '0) begin
					if (now > lp_deadline) begin
						f.long_press = 1'b1;
						press_st = psld_pkg::ST_LONG;
					end
				end else begin
					// long press off: short press repeats while held
					f.short_press = 1'b1;
				end
			end
			psld_pkg::ST_RELEASED: begin
				if (down) begin
					press_st = psld_pkg::ST_PRESSED;
				end else if (now > db_deadline) begin
					if (hold_lp != '0)
						f.short_press = 1'b1;
					press_st = psld_pkg::ST_IDLE;
				end
			end
			psld_pkg::ST_LONG: begin
				if (!down)
					press_st = psld_pkg::ST_IDLE;
			end
			default: begin
				press_st = psld_pkg::ST_IDLE;
			end
		endcase
		return f;
	endfunction

	task automatic report_mismatch(string what);
		mismatches++;
		$display("[%0t] mismatch at result %0d: %s", $realtime, results_seen, what);
	endtask

	// one sample onto s_axis; called and returning at a rising edge
	task automatic send_sample(bit down, logic [psld_pkg::NOW_BITS-1:0] now);
		int unsigned gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 17);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(psld_pkg::IN_BYTES*8-psld_pkg::NOW_BITS-1){1'b0}}, now, down};
		// inputs settle well before the falling edge, so the handshake seen
		// there is the one taken at the next rising edge
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		press_flags_q.push_back(next_press_flags(down, now));
		sent_count++;
		@(posedge clk);
	endtask

	// stop sending and let every expected result come back
	task automatic drain;
		s_tvalid <= 1'b0;
		while (press_flags_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic idx, logic [psld_pkg::CFG_BITS-1:0] val);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == psld_pkg::CFG_DEBOUNCE)
			hold_db = val;
		else
			hold_lp = val;
	endtask

	task automatic set_hold_times(logic [psld_pkg::CFG_BITS-1:0] db,
		logic [psld_pkg::CFG_BITS-1:0] lp);
		write_register(psld_pkg::CFG_DEBOUNCE, db);
		write_register(psld_pkg::CFG_LONG_PRESS, lp);
		tick_max = (int'(db) + int'(lp)) / 16 + 1;
	endtask

	// holds one level for at least span ms, in random time steps
	task automatic hold_level(bit down, int unsigned span);
		int unsigned elapsed;
		int unsigned step;
		elapsed = 0;
		send_sample(down, cur_ms);
		while (elapsed < span) begin
			step = $urandom_range(0, tick_max);
			cur_ms += step;
			elapsed += step;
			send_sample(down, cur_ms);
		end
	endtask

	// reset hold times: bounce, short press, re-press, long press
	task automatic test_press_cycle;
		send_sample(1'b0, 32'd0);
		send_sample(1'b1, 32'd10);     // debounce deadline 30
		send_sample(1'b1, 32'd30);     // equal is not past
		send_sample(1'b1, 32'd31);     // pressed, long deadline 1031
		send_sample(1'b0, 32'd40);     // release debounce
		send_sample(1'b1, 32'd45);     // re-press during release debounce
		send_sample(1'b0, 32'd50);
		send_sample(1'b0, 32'd71);     // short press
		send_sample(1'b1, 32'd100);
		send_sample(1'b0, 32'd110);    // bounce drops back to idle
		send_sample(1'b1, 32'd200);
		send_sample(1'b1, 32'd221);    // pressed, long deadline 1221
		send_sample(1'b1, 32'd1221);
		send_sample(1'b1, 32'd1222);   // long press
		send_sample(1'b1, 32'd1300);   // held in long press, no flags
		send_sample(1'b0, 32'd1301);
	endtask

	// deadlines that wrap past zero are reached at once
	task automatic test_time_wrap;
		send_sample(1'b1, 32'hFFFF_FFF0);
		send_sample(1'b1, 32'hFFFF_FFF1);
		send_sample(1'b1, 32'hFFFF_FFF2);
		send_sample(1'b0, 32'hFFFF_FFFF);
		send_sample(1'b0, 32'h0000_0000);
	endtask

	// zero long press time: short press repeats while held, none on release
	task automatic test_long_disabled;
		set_hold_times(16'd0, 16'd0);
		send_sample(1'b1, 32'd5);
		send_sample(1'b1, 32'd6);
		send_sample(1'b1, 32'd7);
		send_sample(1'b0, 32'd8);
		send_sample(1'b0, 32'd9);
		cur_ms = 32'd9;
	endtask

	// press gestures with bounce, plus noise samples and time jumps
	task automatic random_gestures(int unsigned n_items);
		int unsigned stop_at;
		int unsigned kind;
		int unsigned db;
		int unsigned lp;
		stop_at = sent_count + n_items;
		db = hold_db;
		lp = hold_lp;
		while (sent_count < stop_at) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				// noise: any level at any time
				cur_ms = $urandom;
				send_sample(1'(($urandom_range(0, 1))), cur_ms);
			end else begin
				// some gestures start just below the time wrap
				if (kind == 1)
					cur_ms = 32'hFFFF_FFFF - $urandom_range(0, db + lp + 8);
				repeat ($urandom_range(0, 3)) begin
					hold_level(1'b1, $urandom_range(0, db));
					hold_level(1'b0, $urandom_range(0, db));
				end
				case ($urandom_range(0, 2))
					0:       hold_level(1'b1, $urandom_range(0, db));
					1:       hold_level(1'b1, db + 1 + $urandom_range(0, lp));
					default: hold_level(1'b1, db + lp + 2 + $urandom_range(0, 4 * tick_max));
				endcase
				// release bounce, sometimes back into the press
				repeat ($urandom_range(0, 2)) begin
					hold_level(1'b0, $urandom_range(0, db));
					hold_level(1'b1, $urandom_range(0, db));
				end
				hold_level(1'b0, db + 1 + $urandom_range(0, 2 * tick_max));
			end
		end
	endtask

	task automatic test_random_settings;
		random_gestures(150);
		set_hold_times(16'd0, 16'd0);
		random_gestures(120);
		set_hold_times(16'hFFFF, 16'hFFFF);
		random_gestures(120);
		set_hold_times(16'd3, 16'd0);
		random_gestures(120);
		set_hold_times(16'($urandom_range(0, 200)), 16'($urandom_range(1, 2000)));
		random_gestures(150);
		set_hold_times(16'd0, 16'd1);
		random_gestures(120);
	endtask

	// closing phase at full rate on both sides
	task automatic test_full_rate;
		set_hold_times(16'($urandom_range(0, 50)), 16'($urandom_range(0, 300)));
		idle_on = 1'b0;
		random_gestures(170);
	endtask

	// receiver stalls in random bursts
	always @(posedge clk) begin
		if (!idle_on) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 17) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// result check and hang watchdog; handshakes seen here complete at the
	// next rising edge
	always @(negedge clk) begin
		psld_pkg::flags_t want;
		psld_pkg::flags_t got;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (m_tvalid && m_tready) begin
				got = psld_pkg::flags_t'(m_tdata[1:0]);
				if (press_flags_q.size() == 0) begin
					report_mismatch("result item with nothing expected");
				end else begin
					want = press_flags_q.pop_front();
					if (got.short_press !== want.short_press)
						report_mismatch($sformatf("short_press %b, expected %b",
							got.short_press, want.short_press));
					if (got.long_press !== want.long_press)
						report_mismatch($sformatf("long_press %b, expected %b",
							got.long_press, want.long_press));
				end
				results_seen++;
			end
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("[%0t] watchdog: no item moved for %0d cycles", $realtime,
					HANG_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		m_tready  <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= psld_pkg::CFG_DEBOUNCE;
		cfg_data  <= '0;
		// reset state of the local machine
		press_st     = psld_pkg::ST_IDLE;
		db_deadline  = '0;
		lp_deadline  = '0;
		hold_db      = psld_pkg::DEBOUNCE_RST;
		hold_lp      = psld_pkg::LONG_PRESS_RST;
		tick_max     = (int'(psld_pkg::DEBOUNCE_RST) + int'(psld_pkg::LONG_PRESS_RST)) / 16
		               + 1;
		cur_ms       = '0;
		mismatches   = 0;
		results_seen = 0;
		sent_count   = 0;
		quiet_cycles = 0;
		stall_left   = 0;
		idle_on      = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_press_cycle();
		test_time_wrap();
		// random part starts again from the reset hold times
		drain();
		set_hold_times(psld_pkg::DEBOUNCE_RST, psld_pkg::LONG_PRESS_RST);
		cur_ms = 32'd5000;
		random_gestures(60);
		test_long_disabled();
		test_random_settings();
		test_full_rate();

		drain();
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
